@@ hw/rtl/mse_pkg.sv @@
`timescale 1ns / 1ps

package mse_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned REG_W  = 5;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_LUI     = 6'h0f;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_ORI     = 6'h0d;
   localparam logic [5:0] OP_SLTI    = 6'h0a;
   localparam logic [5:0] OP_SLTIU   = 6'h0b;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2b;

   // function codes under OP_SPECIAL
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_MULT = 6'h18;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;

   typedef enum logic [2:0] {
      KIND_OTHER = 3'd0,
      KIND_ALU   = 3'd1,
      KIND_BEQ   = 3'd2,
      KIND_LOAD  = 3'd3,
      KIND_STORE = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ALU_NONE,
      ALU_ADD,
      ALU_SUB,
      ALU_MULT,
      ALU_AND,
      ALU_OR,
      ALU_SLL,
      ALU_SRL,
      ALU_ADDI,
      ALU_LUI,
      ALU_ANDI,
      ALU_ORI,
      ALU_SLTI,
      ALU_SLTIU
   } alu_op_type;

   typedef struct packed {
      alu_op_type         alu_op;
      logic [4:0]         shamt;
      logic [REG_W-1:0]   target_reg;
      logic [REG_W-1:0]   source_a_reg;
      logic [REG_W-1:0]   source_b_reg;
      logic [WORD_W-1:0]  ext_immediate;
      kind_type           instr_kind;
      logic               is_nop;
      logic               has_immediate;
      logic               two_results;
   } dec_type;

endpackage

@@ hw/rtl/mse_if.sv @@
`timescale 1ns / 1ps

interface mse_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;
   logic [31:0] operand_a;
   logic [31:0] operand_b;

   modport source (output valid, output instr_word, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input instr_word, input operand_a, input operand_b,
                   output ready);
endinterface

interface mse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_low;
   logic [31:0] result_high;
   logic        overflow_flag;
   logic [4:0]  target_reg;
   logic [4:0]  source_a_reg;
   logic [4:0]  source_b_reg;
   logic [31:0] ext_immediate;
   logic [2:0]  instr_kind;
   logic        is_nop;
   logic        has_immediate;
   logic        two_results;

   modport source (output valid, output result_low, output result_high,
                   output overflow_flag, output target_reg, output source_a_reg,
                   output source_b_reg, output ext_immediate, output instr_kind,
                   output is_nop, output has_immediate, output two_results,
                   input ready);
   modport sink   (input valid, input result_low, input result_high,
                   input overflow_flag, input target_reg, input source_a_reg,
                   input source_b_reg, input ext_immediate, input instr_kind,
                   input is_nop, input has_immediate, input two_results,
                   output ready);
endinterface

@@ hw/rtl/mips_subset_decode_execute_core.sv @@
`timescale 1ns / 1ps
// Decode and execute stage for a MIPS32 subset.
// req_bus carries one instruction word with the values of its two source
// registers; rsp_bus returns one beat per request with the decoded class,
// register numbers, extended immediate and, for ALU instructions, the
// result (both product halves for mult, overflow for add, sub and addi).
// Both channels move a beat on a clock edge where valid and ready are high.
// Pipeline: decode -> execute -> output register. A request beat taken on
// req_bus is registered in the decode, execute and output registers in that
// order and shows on rsp_bus from the output register. One beat per cycle is
// sustained, since every stage advances each cycle while rsp_bus.ready is
// high; the 32x32 signed multiplier fills the execute stage on its own.
// When the receiver drops ready, the output register holds its beat and
// each stage holds as soon as the one after it is full and held;
// req_bus.ready falls only when all three stages are occupied. Nothing is
// dropped or repeated.
// Synchronous reset clears the stage valid bits; the pipe is empty and
// ready for a request beat in the first cycle after reset.
module mips_subset_decode_execute_core
   import mse_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mse_req_if.sink   req_bus,
   mse_rsp_if.source rsp_bus
);

   // ---------------- stage handshake ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic adv1, adv2, adv3;

   assign adv3 = !s3_valid_ff || rsp_bus.ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_bus.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_bus.valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------- decode ----------------
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [15:0] imm;
   logic [31:0] sx, zx, lx;
   dec_type     dec_in;

   assign op  = req_bus.instr_word[31:26];
   assign rs  = req_bus.instr_word[25:21];
   assign rt  = req_bus.instr_word[20:16];
   assign rd  = req_bus.instr_word[15:11];
   assign sh  = req_bus.instr_word[10:6];
   assign fn  = req_bus.instr_word[5:0];
   assign imm = req_bus.instr_word[15:0];
   assign sx  = {{16{imm[15]}}, imm};
   assign zx  = {16'h0000, imm};
   assign lx  = {imm, 16'h0000};

   always_comb begin
      dec_in               = '0;
      dec_in.alu_op        = ALU_NONE;
      dec_in.instr_kind    = KIND_OTHER;
      dec_in.shamt         = sh;
      dec_in.is_nop        = (req_bus.instr_word == '0);
      unique case (op)
         OP_SPECIAL: begin
            dec_in.instr_kind   = KIND_ALU;
            dec_in.target_reg   = rd;
            dec_in.source_a_reg = rs;
            dec_in.source_b_reg = rt;
            unique case (fn)
               FN_ADD:  dec_in.alu_op = ALU_ADD;
               FN_SUB:  dec_in.alu_op = ALU_SUB;
               FN_AND:  dec_in.alu_op = ALU_AND;
               FN_OR:   dec_in.alu_op = ALU_OR;
               FN_MULT: begin
                  dec_in.alu_op      = ALU_MULT;
                  dec_in.two_results = 1'b1;
               end
               FN_SLL, FN_SRL: begin
                  // shifts read rt through the first port
                  dec_in.alu_op       = (fn == FN_SLL) ? ALU_SLL : ALU_SRL;
                  dec_in.source_a_reg = rt;
                  dec_in.source_b_reg = '0;
               end
               default: begin
                  dec_in.instr_kind   = KIND_OTHER;
                  dec_in.target_reg   = '0;
                  dec_in.source_a_reg = '0;
                  dec_in.source_b_reg = '0;
               end
            endcase
         end
         OP_ADDI, OP_ANDI, OP_ORI, OP_SLTI, OP_SLTIU: begin
            dec_in.instr_kind    = KIND_ALU;
            dec_in.has_immediate = 1'b1;
            dec_in.target_reg    = rt;
            dec_in.source_a_reg  = rs;
            dec_in.ext_immediate = (op == OP_ANDI || op == OP_ORI) ? zx : sx;
            unique case (op)
               OP_ADDI: dec_in.alu_op = ALU_ADDI;
               OP_ANDI: dec_in.alu_op = ALU_ANDI;
               OP_ORI:  dec_in.alu_op = ALU_ORI;
               OP_SLTI: dec_in.alu_op = ALU_SLTI;
               default: dec_in.alu_op = ALU_SLTIU;
            endcase
         end
         OP_LUI: begin
            dec_in.instr_kind    = KIND_ALU;
            dec_in.has_immediate = 1'b1;
            dec_in.target_reg    = rt;
            dec_in.ext_immediate = lx;
            dec_in.alu_op        = ALU_LUI;
         end
         OP_BEQ: begin
            dec_in.instr_kind    = KIND_BEQ;
            dec_in.has_immediate = 1'b1;
            dec_in.source_a_reg  = rs;
            dec_in.source_b_reg  = rt;
            dec_in.ext_immediate = sx;
         end
         OP_LW: begin
            dec_in.instr_kind    = KIND_LOAD;
            dec_in.has_immediate = 1'b1;
            dec_in.target_reg    = rt;
            dec_in.source_a_reg  = rs;
            dec_in.ext_immediate = sx;
         end
         OP_SW: begin
            dec_in.instr_kind    = KIND_STORE;
            dec_in.has_immediate = 1'b1;
            dec_in.source_a_reg  = rs;
            dec_in.source_b_reg  = rt;
            dec_in.ext_immediate = sx;
         end
         default: ;
      endcase
   end

   dec_type     s1_dec_ff;
   logic [31:0] s1_a_ff, s1_b_ff;

   always_ff @(posedge clock) begin
      if (adv1 && req_bus.valid) begin
         s1_dec_ff <= dec_in;
         s1_a_ff   <= req_bus.operand_a;
         s1_b_ff   <= req_bus.operand_b;
      end
   end

   // ---------------- execute ----------------
   logic        [31:0] opnd_b, sum, diff, alu_lo_in;
   logic               ov_in;
   logic signed [63:0] prod_in;

   // addi adds the extended immediate instead of the second register
   assign opnd_b  = (s1_dec_ff.alu_op == ALU_ADDI) ? s1_dec_ff.ext_immediate : s1_b_ff;
   assign sum     = s1_a_ff + opnd_b;
   assign diff    = s1_a_ff - s1_b_ff;
   assign prod_in = $signed(s1_a_ff) * $signed(s1_b_ff);

   always_comb begin
      alu_lo_in = '0;
      ov_in     = 1'b0;
      unique case (s1_dec_ff.alu_op)
         ALU_ADD, ALU_ADDI: begin
            alu_lo_in = sum;
            ov_in     = ((s1_a_ff[31] ^ sum[31]) & (opnd_b[31] ^ sum[31]));
         end
         ALU_SUB: begin
            alu_lo_in = diff;
            ov_in     = ((s1_a_ff[31] ^ s1_b_ff[31]) & (s1_a_ff[31] ^ diff[31]));
         end
         ALU_AND:   alu_lo_in = s1_a_ff & s1_b_ff;
         ALU_OR:    alu_lo_in = s1_a_ff | s1_b_ff;
         ALU_SLL:   alu_lo_in = s1_a_ff << s1_dec_ff.shamt;
         ALU_SRL:   alu_lo_in = s1_a_ff >> s1_dec_ff.shamt;
         ALU_LUI:   alu_lo_in = s1_dec_ff.ext_immediate;
         ALU_ANDI:  alu_lo_in = s1_a_ff & s1_dec_ff.ext_immediate;
         ALU_ORI:   alu_lo_in = s1_a_ff | s1_dec_ff.ext_immediate;
         ALU_SLTI:  alu_lo_in = {31'd0,
                                 $signed(s1_a_ff) < $signed(s1_dec_ff.ext_immediate)};
         ALU_SLTIU: alu_lo_in = {31'd0, s1_a_ff < s1_dec_ff.ext_immediate};
         default:   alu_lo_in = '0;
      endcase
   end

   dec_type     s2_dec_ff;
   logic [31:0] s2_lo_ff;
   logic        s2_ov_ff;
   logic [63:0] s2_prod_ff;

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         s2_dec_ff  <= s1_dec_ff;
         s2_lo_ff   <= alu_lo_in;
         s2_ov_ff   <= ov_in;
         s2_prod_ff <= prod_in;
      end
   end

   // ---------------- output register ----------------
   dec_type     s3_dec_ff;
   logic [31:0] s3_lo_ff, s3_hi_ff;
   logic        s3_ov_ff;

   always_ff @(posedge clock) begin
      if (adv3 && s2_valid_ff) begin
         s3_dec_ff <= s2_dec_ff;
         s3_ov_ff  <= s2_ov_ff;
         s3_lo_ff  <= s2_dec_ff.two_results ? s2_prod_ff[31:0] : s2_lo_ff;
         s3_hi_ff  <= s2_dec_ff.two_results ? s2_prod_ff[63:32] : 32'd0;
      end
   end

   assign rsp_bus.valid         = s3_valid_ff;
   assign rsp_bus.result_low    = s3_lo_ff;
   assign rsp_bus.result_high   = s3_hi_ff;
   assign rsp_bus.overflow_flag = s3_ov_ff;
   assign rsp_bus.target_reg    = s3_dec_ff.target_reg;
   assign rsp_bus.source_a_reg  = s3_dec_ff.source_a_reg;
   assign rsp_bus.source_b_reg  = s3_dec_ff.source_b_reg;
   assign rsp_bus.ext_immediate = s3_dec_ff.ext_immediate;
   assign rsp_bus.instr_kind    = s3_dec_ff.instr_kind;
   assign rsp_bus.is_nop        = s3_dec_ff.is_nop;
   assign rsp_bus.has_immediate = s3_dec_ff.has_immediate;
   assign rsp_bus.two_results   = s3_dec_ff.two_results;

   // ---------------- assertions ----------------
   a_two_is_alu: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.two_results |-> rsp_bus.instr_kind == KIND_ALU)
      else $error("mult beat not marked as ALU");

   a_hi_only_mult: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.two_results |-> rsp_bus.result_high == '0)
      else $error("result_high set outside mult");

   a_ov_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.overflow_flag |->
         !rsp_bus.two_results && rsp_bus.instr_kind == KIND_ALU)
      else $error("overflow on a non add/sub beat");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && s3_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken with full pipe");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench
   import mse_pkg::*;
();

   localparam int RANDOM_ITEMS  = 1525;
   localparam int STALL_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int REPORT_LIMIT  = 10;
   localparam int HOLD_CYCLES   = 150;

   typedef struct packed {
      logic [31:0] result_low;
      logic [31:0] result_high;
      logic        overflow_flag;
      logic [4:0]  target_reg;
      logic [4:0]  source_a_reg;
      logic [4:0]  source_b_reg;
      logic [31:0] ext_immediate;
      kind_type    instr_kind;
      logic        is_nop;
      logic        has_immediate;
      logic        two_results;
   } exec_result_type;

   typedef struct {
      logic [31:0]     word;
      logic [31:0]     opnd_a;
      logic [31:0]     opnd_b;
      bit              typed;
      exec_result_type result;
   } stim_row_type;

   logic clock;
   logic reset;

   mse_req_if req_bus ();
   mse_rsp_if rsp_bus ();

   exec_result_type pending_results[$];
   stim_row_type    directed_rows[$];
   int              result_errors = 0;
   int              rsp_count = 0;

   mips_subset_decode_execute_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic exec_result_type decode_execute(input logic [31:0] w, a, b);
      exec_result_type    res;
      logic [4:0]         rs, rt, rd, sh;
      logic [15:0]        imm;
      logic [31:0]        sx, sum;
      logic signed [63:0] prod;
      rs  = w[25:21];
      rt  = w[20:16];
      rd  = w[15:11];
      sh  = w[10:6];
      imm = w[15:0];
      sx  = {{16{imm[15]}}, imm};
      res = '0;
      res.is_nop = (w == 32'd0);
      if (w[31:26] == OP_SPECIAL) begin
         case (w[5:0])
            FN_ADD: begin
               sum = a + b;
               res.result_low = sum;
               res.overflow_flag = (a[31] == b[31]) && (sum[31] != a[31]);
            end
            FN_SUB: begin
               sum = a - b;
               res.result_low = sum;
               res.overflow_flag = (a[31] != b[31]) && (sum[31] != a[31]);
            end
            FN_MULT: begin
               prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
               res.result_low  = prod[31:0];
               res.result_high = prod[63:32];
               res.two_results = 1'b1;
            end
            FN_AND:  res.result_low = a & b;
            FN_OR:   res.result_low = a | b;
            FN_SLL:  res.result_low = a << sh;
            FN_SRL:  res.result_low = a >> sh;
            default: return res;
         endcase
         res.instr_kind = KIND_ALU;
         res.target_reg = rd;
         // shifts read rt through the first port and nothing through the second
         if (w[5:0] == FN_SLL || w[5:0] == FN_SRL) begin
            res.source_a_reg = rt;
         end else begin
            res.source_a_reg = rs;
            res.source_b_reg = rt;
         end
      end else begin
         res.has_immediate = 1'b1;
         res.source_a_reg  = rs;
         res.target_reg    = rt;
         res.ext_immediate = sx;
         res.instr_kind    = KIND_ALU;
         case (w[31:26])
            OP_ADDI: begin
               sum = a + sx;
               res.result_low = sum;
               res.overflow_flag = (a[31] == sx[31]) && (sum[31] != a[31]);
            end
            OP_LUI: begin
               res.source_a_reg  = '0;
               res.ext_immediate = {imm, 16'h0000};
               res.result_low    = {imm, 16'h0000};
            end
            OP_ANDI: begin
               res.ext_immediate = {16'h0000, imm};
               res.result_low    = a & {16'h0000, imm};
            end
            OP_ORI: begin
               res.ext_immediate = {16'h0000, imm};
               res.result_low    = a | {16'h0000, imm};
            end
            OP_SLTI:  res.result_low = ($signed(a) < $signed(sx)) ? 32'd1 : 32'd0;
            OP_SLTIU: res.result_low = (a < sx) ? 32'd1 : 32'd0;
            OP_BEQ: begin
               res.instr_kind   = KIND_BEQ;
               res.target_reg   = '0;
               res.source_b_reg = rt;
            end
            OP_LW:   res.instr_kind = KIND_LOAD;
            OP_SW: begin
               res.instr_kind   = KIND_STORE;
               res.target_reg   = '0;
               res.source_b_reg = rt;
            end
            default: begin
               res = '0;
               res.is_nop = (w == 32'd0);
            end
         endcase
      end
      return res;
   endfunction

   function automatic logic [31:0] enc_r(input logic [5:0] fn,
                                         input logic [4:0] rs, rt, rd, sh);
      return {OP_SPECIAL, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs, rt,
                                         input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic exec_result_type make_rsp(input logic [31:0] lo, hi, input logic ov,
                                                input logic [4:0] tgt, sa, sb,
                                                input logic [31:0] ext,
                                                input kind_type kind,
                                                input logic nop, himm, two);
      exec_result_type res;
      res.result_low    = lo;
      res.result_high   = hi;
      res.overflow_flag = ov;
      res.target_reg    = tgt;
      res.source_a_reg  = sa;
      res.source_b_reg  = sb;
      res.ext_immediate = ext;
      res.instr_kind    = kind;
      res.is_nop        = nop;
      res.has_immediate = himm;
      res.two_results   = two;
      return res;
   endfunction

   task automatic add_typed(input logic [31:0] w, a, b, input exec_result_type res);
      stim_row_type row;
      row.word   = w;
      row.opnd_a = a;
      row.opnd_b = b;
      row.typed  = 1'b1;
      row.result = res;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_checked(input logic [31:0] w, a, b);
      add_typed(w, a, b, '0);
      directed_rows[directed_rows.size()-1].typed = 1'b0;
   endtask

   function automatic logic [31:0] random_instr();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 19))
         0:  w = {OP_SPECIAL, w[25:6], FN_ADD};
         1:  w = {OP_SPECIAL, w[25:6], FN_SUB};
         2:  w = {OP_SPECIAL, w[25:6], FN_MULT};
         3:  w = {OP_SPECIAL, w[25:6], FN_AND};
         4:  w = {OP_SPECIAL, w[25:6], FN_OR};
         5:  w = {OP_SPECIAL, w[25:6], FN_SLL};
         6:  w = {OP_SPECIAL, w[25:6], FN_SRL};
         7:  w[31:26] = OP_ADDI;
         8:  w[31:26] = OP_LUI;
         9:  w[31:26] = OP_ANDI;
         10: w[31:26] = OP_ORI;
         11: w[31:26] = OP_SLTI;
         12: w[31:26] = OP_SLTIU;
         13: w[31:26] = OP_BEQ;
         14: w[31:26] = OP_LW;
         15: w[31:26] = OP_SW;
         16: w[31:26] = OP_SPECIAL;
         17: w = 32'd0;
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h8000_0000;
         3:       return 32'h7fff_ffff;
         4:       return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // hold one beat on req_bus until it is taken, then record what it must produce
   task automatic offer_beat(input logic [31:0] w, a, b, input exec_result_type res);
      req_bus.valid      = 1'b1;
      req_bus.instr_word = w;
      req_bus.operand_a  = a;
      req_bus.operand_b  = b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_results.insert(pending_results.size(), res);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         result_errors++;
         if (result_errors <= REPORT_LIMIT)
            $display("result %0d: %s expected %h, got %h", rsp_count, name, want, got);
      end
   endtask

   initial begin : stimulus
      int           burst_left;
      int           gap;
      int           total;
      stim_row_type row;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.instr_word = '0;
      req_bus.operand_a  = '0;
      req_bus.operand_b  = '0;

      add_typed(32'd0, 32'd0, 32'd0,
                make_rsp(0, 0, 0, 0, 0, 0, 0, KIND_ALU, 1, 0, 0));
      add_typed(enc_r(FN_ADD, 1, 2, 3, 0), 32'h7fff_ffff, 32'd1,
                make_rsp(32'h8000_0000, 0, 1, 3, 1, 2, 0, KIND_ALU, 0, 0, 0));
      add_checked(enc_r(FN_ADD, 4, 5, 6, 7), 32'h8000_0000, 32'h8000_0000);
      add_typed(enc_r(FN_SUB, 31, 30, 31, 0), 32'h8000_0000, 32'd1,
                make_rsp(32'h7fff_ffff, 0, 1, 31, 31, 30, 0, KIND_ALU, 0, 0, 0));
      add_checked(enc_r(FN_SUB, 1, 1, 1, 31), 32'd0, 32'h8000_0000);
      add_typed(enc_r(FN_MULT, 6, 7, 5, 0), 32'hffff_ffff, 32'hffff_ffff,
                make_rsp(32'd1, 0, 0, 5, 6, 7, 0, KIND_ALU, 0, 0, 1));
      add_checked(enc_r(FN_MULT, 8, 9, 0, 0), 32'h8000_0000, 32'h8000_0000);
      add_checked(enc_r(FN_MULT, 10, 11, 12, 0), 32'h7fff_ffff, 32'h8000_0000);
      add_checked(enc_r(FN_AND, 13, 14, 15, 0), 32'hf0f0_a5a5, 32'hffff_0000);
      add_checked(enc_r(FN_OR, 16, 17, 18, 0), 32'h0f0f_0000, 32'h0000_5a5a);
      add_typed(enc_r(FN_SLL, 0, 8, 9, 31), 32'd1, 32'd0,
                make_rsp(32'h8000_0000, 0, 0, 9, 8, 0, 0, KIND_ALU, 0, 0, 0));
      add_typed(enc_r(FN_SRL, 4, 11, 10, 31), 32'hffff_ffff, 32'hffff_ffff,
                make_rsp(32'd1, 0, 0, 10, 11, 0, 0, KIND_ALU, 0, 0, 0));
      add_typed(enc_i(OP_ADDI, 13, 12, 16'h0001), 32'h7fff_ffff, 32'd0,
                make_rsp(32'h8000_0000, 0, 1, 12, 13, 0, 32'd1, KIND_ALU, 0, 1, 0));
      add_checked(enc_i(OP_ADDI, 2, 3, 16'hffff), 32'h8000_0000, 32'd5);
      add_typed(enc_i(OP_LUI, 17, 18, 16'hffff), 32'h1234_5678, 32'h9abc_def0,
                make_rsp(32'hffff_0000, 0, 0, 18, 0, 0, 32'hffff_0000, KIND_ALU, 0, 1, 0));
      add_checked(enc_i(OP_ANDI, 19, 20, 16'hffff), 32'hffff_ffff, 32'd0);
      add_checked(enc_i(OP_ORI, 21, 22, 16'h8000), 32'h0000_0001, 32'd0);
      add_checked(enc_i(OP_SLTI, 23, 24, 16'h7fff), 32'h8000_0000, 32'd0);
      add_checked(enc_i(OP_SLTI, 25, 26, 16'h8000), 32'd0, 32'd0);
      add_checked(enc_i(OP_SLTIU, 27, 28, 16'hffff), 32'hffff_fffe, 32'd0);
      add_checked(enc_i(OP_BEQ, 29, 30, 16'h8000), 32'd7, 32'd7);
      add_checked(enc_i(OP_LW, 31, 1, 16'h8000), 32'h1000_0000, 32'd0);
      add_checked(enc_i(OP_SW, 2, 31, 16'h7fff), 32'h1000_0000, 32'hdead_beef);
      add_typed(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                make_rsp(0, 0, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0));
      add_typed({OP_SPECIAL, 20'hfffff, 6'h3f}, 32'hffff_ffff, 32'hffff_ffff,
                make_rsp(0, 0, 0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      total = directed_rows.size() + RANDOM_ITEMS;
      burst_left = 0;
      for (int i = 0; i < total; i++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_bus.valid = 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
         end
         burst_left--;
         if (i < directed_rows.size()) begin
            row = directed_rows[i];
         end else begin
            row.word   = random_instr();
            row.opnd_a = random_operand();
            row.opnd_b = random_operand();
            row.typed  = 1'b0;
         end
         if (!row.typed)
            row.result = decode_execute(row.word, row.opnd_a, row.opnd_b);
         offer_beat(row.word, row.opnd_a, row.opnd_b, row.result);
      end
      req_bus.valid = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (result_errors == 0 && pending_results.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin : rsp_pacing
      int cycle_count;
      int hold_left;
      int mode;
      rsp_bus.ready = 1'b0;
      cycle_count = 0;
      hold_left = 0;
      mode = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         cycle_count++;
         // long hold-offs so the pipe fills and backs up into req_bus
         if (cycle_count == 300 || cycle_count == 1500)
            hold_left = HOLD_CYCLES;
         if (cycle_count % 64 == 0)
            mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            case (mode)
               0:       rsp_bus.ready = 1'b1;
               1:       rsp_bus.ready = ($urandom_range(0, 1) == 0);
               2:       rsp_bus.ready = ($urandom_range(0, 9) != 0);
               default: rsp_bus.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      exec_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         rsp_count++;
         if (pending_results.size() == 0) begin
            result_errors++;
            if (result_errors <= REPORT_LIMIT)
               $display("result %0d: beat with nothing outstanding", rsp_count);
         end else begin
            want = pending_results.pop_front();
            check_field("result_low", want.result_low, rsp_bus.result_low);
            check_field("result_high", want.result_high, rsp_bus.result_high);
            check_field("overflow_flag", 32'(want.overflow_flag),
                        32'(rsp_bus.overflow_flag));
            check_field("target_reg", 32'(want.target_reg), 32'(rsp_bus.target_reg));
            check_field("source_a_reg", 32'(want.source_a_reg),
                        32'(rsp_bus.source_a_reg));
            check_field("source_b_reg", 32'(want.source_b_reg),
                        32'(rsp_bus.source_b_reg));
            check_field("ext_immediate", want.ext_immediate, rsp_bus.ext_immediate);
            check_field("instr_kind", 32'(want.instr_kind), 32'(rsp_bus.instr_kind));
            check_field("is_nop", 32'(want.is_nop), 32'(rsp_bus.is_nop));
            check_field("has_immediate", 32'(want.has_immediate),
                        32'(rsp_bus.has_immediate));
            check_field("two_results", 32'(want.two_results),
                        32'(rsp_bus.two_results));
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("testbench NOT OK");
      $finish;
   end

endmodule

@@ mips_subset_decode_execute_core.f @@
hw/rtl/mse_pkg.sv
hw/rtl/mse_if.sv
hw/rtl/mips_subset_decode_execute_core.sv
tb/testbench.sv
